[design/wsg_pkg.sv]
package wsg_pkg;

	localparam int unsigned WAVE_LENGTH    = 1024;
	localparam int unsigned INDEX_W        = 10;
	localparam int unsigned QUARTER        = WAVE_LENGTH / 4;
	localparam int unsigned QUARTER_W      = INDEX_W - 2;
	localparam int unsigned HALF_W         = INDEX_W - 1;
	localparam int unsigned GAIN_FRAC_BITS = 12;
	localparam int unsigned RAW_W          = 13;
	localparam int unsigned GAIN_W         = 16;
	localparam int unsigned SCALED_W       = 16;
	localparam int unsigned PROD_W         = RAW_W + GAIN_W;

	localparam logic [11:0] FULL_SCALE = 12'd4095;
	localparam logic [RAW_W-1:0] MID_SCALE = 13'd2048;
	localparam logic [RAW_W-1:0] PEAK_SCALE = 13'd4096;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAVE_TYPE = 2'd0;
	localparam logic [1:0] REG_GAIN      = 2'd1;

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_SQUARE   = 3'd1,
		WAVE_RAMP     = 3'd2,
		WAVE_TRIANGLE = 3'd3,
		WAVE_DC       = 3'd4
	} wave_t;

	// One ROM entry: bits [12:1] hold the Q30 sine shifted down by 19,
	// bit 0 tells whether any of the dropped bits were set.
	typedef logic [QUARTER-1:0][12:0] sine_rom_t;

	function automatic logic [12:0] sine_entry(int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [64:0] sum;
		logic [63:0] r;
		r = 64'(4 * k);
		x = (HALF_PI_Q30 * r) / WAVE_LENGTH;
		x2 = (x * x) >> 30;
		term = x;
		sum = 65'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - 65'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + 65'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - 65'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + 65'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - 65'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + 65'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - 65'(term);
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed({1'b0, Q30_ONE})) begin
			sum = $signed({1'b0, Q30_ONE});
		end
		return {sum[30:19], (sum[18:0] != 19'd0)};
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int unsigned k = 0; k < QUARTER; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[design/waveform_sample_generator.sv]
// Waveform sample generator.
// Each item is one sample_index within a period of 1024 samples. The block
// returns the raw sample of the selected wave (sine, square, ramp, triangle,
// or zero for dc and unused codes) and that sample times the Q4.12 gain,
// shifted right by 12 and saturated at 65535.
// Input: an item is taken on any clock edge where start is high; busy never
// rises, so one item enters every cycle.
// Output: done is high for one cycle with raw_sample and scaled_sample; the
// receiver cannot stall, and items leave in the order they entered.
// The pipeline has four stages: index capture, quarter-wave ROM lookup with
// symmetry fold, gain multiply, then shift and saturate.
// Configuration: cfg_ready is always high; index 0 is wave_type, index 1 is
// gain, other indexes are ignored. Write only while no item is in flight.
// Reset clears the pipeline valid bits and sets wave_type to sine and gain
// to unity (4096).
module waveform_sample_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  sample_index,
	output logic        done,
	output logic [12:0] raw_sample,
	output logic [15:0] scaled_sample,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [2:0] wave_type_q;
	logic [wsg_pkg::GAIN_W-1:0] gain_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic [wsg_pkg::INDEX_W-1:0] index_s1;
	logic [wsg_pkg::RAW_W-1:0] raw_s2, raw_s3, raw_s4;
	logic [wsg_pkg::PROD_W-1:0] prod_s3;
	logic [wsg_pkg::SCALED_W-1:0] scaled_s4;

	logic [1:0] quad;
	logic [wsg_pkg::QUARTER_W-1:0] step;
	logic [wsg_pkg::QUARTER_W-1:0] rom_addr;
	logic [12:0] rom_entry;
	logic full;
	logic [wsg_pkg::RAW_W-1:0] sine_raw;
	logic [wsg_pkg::RAW_W-1:0] wave_raw;
	logic [wsg_pkg::INDEX_W+11:0] ramp_prod;
	logic [wsg_pkg::HALF_W+11:0] tri_prod;
	logic [wsg_pkg::HALF_W-1:0] tri_offset;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q <= wsg_pkg::WAVE_SINE;
			gain_q <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == wsg_pkg::REG_WAVE_TYPE) begin
				wave_type_q <= cfg_data[2:0];
			end else if (cfg_index == wsg_pkg::REG_GAIN) begin
				gain_q <= cfg_data;
			end
		end
	end

	// Quarter-wave fold: odd quadrants mirror the index, the upper half
	// subtracts from mid-scale. The end of a quarter is exactly peak scale, or zero in the upper half.
	assign quad = index_s1[wsg_pkg::INDEX_W-1 -: 2];
	assign step = index_s1[wsg_pkg::QUARTER_W-1:0];
	assign full = quad[0] && (step == '0);
	assign rom_addr = quad[0] ? (wsg_pkg::QUARTER_W)'(0) - step : step;
	assign rom_entry = wsg_pkg::SINE_ROM[rom_addr];

	always_comb begin
		if (full) begin
			sine_raw = quad[1] ? '0 : wsg_pkg::PEAK_SCALE;
		end else if (quad[1]) begin
			sine_raw = wsg_pkg::MID_SCALE - {1'b0, rom_entry[12:1]}
				- {12'd0, rom_entry[0]};
		end else begin
			sine_raw = wsg_pkg::MID_SCALE + {1'b0, rom_entry[12:1]};
		end
	end

	// Multiplying by 4095 is a shift and a subtract.
	assign ramp_prod = {index_s1, 12'd0} - {12'd0, index_s1};
	assign tri_offset = index_s1[wsg_pkg::HALF_W-1:0];
	assign tri_prod = {tri_offset, 12'd0} - {12'd0, tri_offset};

	always_comb begin
		case (wsg_pkg::wave_t'(wave_type_q))
			wsg_pkg::WAVE_SINE: wave_raw = sine_raw;
			wsg_pkg::WAVE_SQUARE: begin
				wave_raw = index_s1[wsg_pkg::INDEX_W-1] ? '0
					: {1'b0, wsg_pkg::FULL_SCALE};
			end
			wsg_pkg::WAVE_RAMP: begin
				wave_raw = {1'b0, ramp_prod[wsg_pkg::INDEX_W+11:wsg_pkg::INDEX_W]};
			end
			wsg_pkg::WAVE_TRIANGLE: begin
				if (index_s1[wsg_pkg::INDEX_W-1]) begin
					wave_raw = {1'b0, wsg_pkg::FULL_SCALE
						- tri_prod[wsg_pkg::HALF_W+11:wsg_pkg::HALF_W]};
				end else begin
					wave_raw = {1'b0, tri_prod[wsg_pkg::HALF_W+11:wsg_pkg::HALF_W]};
				end
			end
			default: wave_raw = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= sample_index;
		raw_s2 <= wave_raw;
		raw_s3 <= raw_s2;
		prod_s3 <= {{wsg_pkg::GAIN_W{1'b0}}, raw_s2} * {{wsg_pkg::RAW_W{1'b0}}, gain_q};
		raw_s4 <= raw_s3;
		if (prod_s3[wsg_pkg::PROD_W-1:wsg_pkg::GAIN_FRAC_BITS + wsg_pkg::SCALED_W] != '0) begin
			scaled_s4 <= '1;
		end else begin
			scaled_s4 <= prod_s3[wsg_pkg::GAIN_FRAC_BITS +: wsg_pkg::SCALED_W];
		end
	end

	assign done = valid_s4;
	assign raw_sample = raw_s4;
	assign scaled_sample = scaled_s4;

endmodule

[tb/waveform_sample_checker.sv]
`timescale 1ns / 1ps

module waveform_sample_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [9:0]  sample_index,
	input  logic        done,
	input  logic [12:0] raw_sample,
	input  logic [15:0] scaled_sample,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          compared
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [9:0]  index;
		logic [2:0]  wave;
		logic [15:0] gain;
		logic [12:0] raw;
		logic [15:0] scaled;
	} sample_t;

	sample_t    pending_samples[$];
	logic [2:0] wave_sel;
	logic [15:0] gain_q412;

	// Sine over the first quarter in Q30: r runs 0..WAVE_LENGTH across 0..pi/2.
	// The series goes up to x^15 with every product truncated.
	function automatic longint unsigned quarter_sin_q30(input longint unsigned r);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          acc;
		int              k;
		if (r >= wsg_pkg::WAVE_LENGTH) begin
			return wsg_pkg::Q30_ONE;
		end
		ang = (wsg_pkg::HALF_PI_Q30 * r) / wsg_pkg::WAVE_LENGTH;
		ang_sq = (ang * ang) >> 30;
		term = ang;
		acc = longint'(ang);
		for (k = 1; k <= 7; k++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(wsg_pkg::Q30_ONE)) begin
			acc = longint'(wsg_pkg::Q30_ONE);
		end
		return longint'(acc);
	endfunction

	function automatic logic [12:0] sine_level(input longint unsigned p);
		longint unsigned t;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned s;
		longint unsigned v;
		t = 4 * p;
		quad = t / wsg_pkg::WAVE_LENGTH;
		r = t % wsg_pkg::WAVE_LENGTH;
		// Odd quadrants run the quarter backwards, the second half goes below midscale.
		if (quad[0]) begin
			s = quarter_sin_q30(wsg_pkg::WAVE_LENGTH - r);
		end else begin
			s = quarter_sin_q30(r);
		end
		if (quad >= 2) begin
			v = wsg_pkg::Q30_ONE - s;
		end else begin
			v = wsg_pkg::Q30_ONE + s;
		end
		return 13'(v >> 19);
	endfunction

	function automatic logic [12:0] wave_level(input logic [2:0] wave,
		input logic [9:0] idx);
		longint unsigned p;
		longint unsigned half;
		p = idx % wsg_pkg::WAVE_LENGTH;
		half = wsg_pkg::WAVE_LENGTH / 2;
		case (wave)
			wsg_pkg::WAVE_SINE: begin
				return sine_level(p);
			end
			wsg_pkg::WAVE_SQUARE: begin
				return (p < half) ? 13'(wsg_pkg::FULL_SCALE) : 13'd0;
			end
			wsg_pkg::WAVE_RAMP: begin
				return 13'((p * wsg_pkg::FULL_SCALE) / wsg_pkg::WAVE_LENGTH);
			end
			wsg_pkg::WAVE_TRIANGLE: begin
				if (p < half) begin
					return 13'((p * wsg_pkg::FULL_SCALE) / half);
				end
				return 13'(wsg_pkg::FULL_SCALE - ((p - half) * wsg_pkg::FULL_SCALE) / half);
			end
			default: begin
				return 13'd0;
			end
		endcase
	endfunction

	function automatic sample_t predict_sample(input logic [9:0] idx);
		sample_t         s;
		longint unsigned prod;
		s.index = idx;
		s.wave = wave_sel;
		s.gain = gain_q412;
		s.raw = wave_level(wave_sel, idx);
		prod = (longint'(s.raw) * gain_q412) >> wsg_pkg::GAIN_FRAC_BITS;
		s.scaled = (prod > 65535) ? 16'hFFFF : 16'(prod);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t exp_s;
		if (!arst_n) begin
			pending_samples.delete();
			wave_sel = wsg_pkg::WAVE_SINE;
			gain_q412 = 16'd4096;
			mismatches = 0;
			outstanding = 0;
			compared = 0;
		end else begin
			if (done) begin
				if (pending_samples.size() == 0) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("%0t: raw %0d scaled %0d with nothing pending",
							$realtime, raw_sample, scaled_sample);
					end
					mismatches++;
				end else begin
					exp_s = pending_samples.pop_front();
					compared++;
					if (raw_sample !== exp_s.raw || scaled_sample !== exp_s.scaled) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("%0t: index %0d wave %0d gain %0d:",
								$realtime, exp_s.index, exp_s.wave, exp_s.gain);
							$display("  raw exp %0d got %0d, scaled exp %0d got %0d",
								exp_s.raw, raw_sample, exp_s.scaled, scaled_sample);
						end
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				pending_samples.push_back(predict_sample(sample_index));
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == wsg_pkg::REG_WAVE_TYPE) begin
					wave_sel = cfg_data[2:0];
				end else if (cfg_index == wsg_pkg::REG_GAIN) begin
					gain_q412 = cfg_data;
				end
			end
			outstanding = pending_samples.size();
		end
	end

endmodule

[tb/waveform_sample_generator_tb.sv]
`timescale 1ns / 1ps

module waveform_sample_generator_tb;

	localparam logic [1:0]  REG_UNUSED_LO = 2'd2;
	localparam logic [1:0]  REG_UNUSED_HI = 2'd3;
	localparam logic [2:0]  WAVE_CODE_MAX = 3'd7;
	localparam logic [15:0] UNITY_GAIN    = 16'd4096;
	localparam logic [15:0] MAX_GAIN      = 16'hFFFF;
	localparam int SEGMENTS      = 12;
	localparam int ITEMS_PER_SEG = 75;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [9:0]  sample_index;
	logic        done;
	logic [12:0] raw_sample;
	logic [15:0] scaled_sample;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatches;
	int outstanding;
	int compared;
	int idle_pct;
	int sent_count;
	int cfg_count;
	int quiet_cycles;

	waveform_sample_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_index (sample_index),
		.done         (done),
		.raw_sample   (raw_sample),
		.scaled_sample(scaled_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	waveform_sample_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_index (sample_index),
		.done         (done),
		.raw_sample   (raw_sample),
		.scaled_sample(scaled_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.compared     (compared)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Any accepted item, register write or result counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_sample(input logic [9:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			sample_index <= 10'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		sample_index <= idx;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sent_count++;
	endtask

	// Stop sending, let every pending sample come back, then let the
	// pipeline settle before anything is reconfigured.
	task automatic drain_samples();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_count++;
	endtask

	function automatic logic [9:0] pick_index();
		// One in eight lands next to a quadrant boundary.
		if ($urandom_range(7) == 0) begin
			return 10'(256 * $urandom_range(3) + $urandom_range(2) + 1023);
		end
		return 10'($urandom_range(1023));
	endfunction

	initial begin
		int          sine_points[7];
		int          w;
		int          seg;
		int          n;
		logic [2:0]  wave;
		logic [15:0] gain;

		sine_points = '{0, 256, 512, 768, 1023, 255, 257};
		arst_n = 1'b0;
		start = 1'b0;
		sample_index = '0;
		cfg_valid = 1'b0;
		cfg_index = wsg_pkg::REG_WAVE_TYPE;
		cfg_data = '0;
		idle_pct = 0;
		sent_count = 0;
		cfg_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset state: sine at unity gain, through peak, trough and zero crossings.
		foreach (sine_points[i]) begin
			send_sample(10'(sine_points[i]));
		end

		// Writes to indexes outside the map must leave the registers alone.
		drain_samples();
		write_reg(REG_UNUSED_LO, MAX_GAIN);
		write_reg(REG_UNUSED_HI, 16'(wsg_pkg::WAVE_SQUARE));
		send_sample(10'd128);

		drain_samples();
		write_reg(wsg_pkg::REG_WAVE_TYPE, 16'(wsg_pkg::WAVE_SQUARE));
		write_reg(wsg_pkg::REG_GAIN, MAX_GAIN);
		send_sample(10'd511);
		send_sample(10'd512);
		send_sample(10'd0);

		drain_samples();
		write_reg(wsg_pkg::REG_WAVE_TYPE, 16'(wsg_pkg::WAVE_RAMP));
		send_sample(10'd0);
		send_sample(10'd1023);

		drain_samples();
		write_reg(wsg_pkg::REG_WAVE_TYPE, 16'(wsg_pkg::WAVE_TRIANGLE));
		write_reg(wsg_pkg::REG_GAIN, 16'd1);
		send_sample(10'd511);
		send_sample(10'd512);
		send_sample(10'd513);

		drain_samples();
		write_reg(wsg_pkg::REG_WAVE_TYPE, 16'(wsg_pkg::WAVE_DC));
		write_reg(wsg_pkg::REG_GAIN, MAX_GAIN);
		send_sample(10'd1023);

		// Selector codes past dc produce silence; upper data bits are don't-care.
		for (w = int'(wsg_pkg::WAVE_DC) + 1; w <= int'(WAVE_CODE_MAX); w++) begin
			drain_samples();
			write_reg(wsg_pkg::REG_WAVE_TYPE, {13'h1FFF, 3'(w)});
			send_sample(10'd256);
		end

		drain_samples();
		write_reg(wsg_pkg::REG_WAVE_TYPE, 16'(wsg_pkg::WAVE_SINE));
		write_reg(wsg_pkg::REG_GAIN, 16'd0);
		send_sample(10'd256);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain_samples();
			case (seg % 4)
				0: idle_pct = 0;
				1: idle_pct = 64;
				2: idle_pct = 0;
				default: idle_pct = 16;
			endcase
			wave = (seg < 10) ? 3'(seg % 5) : 3'($urandom_range(7));
			case ($urandom_range(4))
				0: gain = 16'd0;
				1: gain = MAX_GAIN;
				2: gain = UNITY_GAIN;
				default: gain = 16'($urandom);
			endcase
			write_reg(wsg_pkg::REG_WAVE_TYPE, {13'($urandom), wave});
			write_reg(wsg_pkg::REG_GAIN, gain);
			if ($urandom_range(3) == 0) begin
				write_reg($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO, 16'($urandom));
			end
			for (n = 0; n < ITEMS_PER_SEG; n++) begin
				if (seg == 5 && n == ITEMS_PER_SEG / 2) begin
					drain_samples();
				end
				send_sample(pick_index());
			end
		end

		drain_samples();
		$display("Drove %0d sample indexes through %0d register writes,", sent_count,
			cfg_count);
		$display("all wave codes and gain extremes; compared %0d samples, %0d mismatched.",
			compared, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[filelist.f]
design/wsg_pkg.sv
design/waveform_sample_generator.sv
tb/waveform_sample_checker.sv
tb/waveform_sample_generator_tb.sv
